### src/esbr_pkg.sv
`default_nettype none
package esbr_pkg;

    localparam int ROM_PAGE_DEPTH    = 256;
    localparam int STROBE_AREA_DEPTH = 2048;
    localparam int REGISTER_COUNT    = 16;

    localparam int ROM_AW = $clog2(ROM_PAGE_DEPTH);
    localparam int STR_AW = $clog2(STROBE_AREA_DEPTH);
    localparam int REG_AW = $clog2(REGISTER_COUNT);

    localparam int PADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_ROM_PAGE_BASE = 1'b0;
    localparam logic REG_REGISTER_BASE = 1'b1;

    localparam logic [15:0] ROM_PAGE_BASE_RESET = 16'hc100;
    localparam logic [15:0] REGISTER_BASE_RESET = 16'hc090;

    localparam logic [15:0] PAGE_MASK         = 16'hff00;
    localparam logic [15:0] STROBE_MASK       = 16'hf800;
    localparam logic [15:0] STROBE_BASE       = 16'hc800;
    localparam logic [15:0] REG_MASK          = 16'hfff0;
    localparam logic [15:0] STROBE_CLEAR_ADDR = 16'hcfff;

    localparam logic FUNC_BUS_CYCLE = 1'b0;
    localparam logic FUNC_PRELOAD   = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] bus_address;
        logic [2:0]  control_bits;
        logic [7:0]  bus_data;
    } t_in_word;

    typedef struct packed {
        logic       card_drives;
        logic [7:0] drive_byte;
        logic [7:0] cycle_byte;
        logic       strobe_latched;
    } t_out_word;

    typedef struct packed {
        logic        rom_we;
        logic        str_we;
        logic        reg_we;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_store_wr;

    typedef struct packed {
        logic [7:0] rom_q;
        logic [7:0] str_q;
        logic [7:0] reg_q;
    } t_store_rd;

endpackage
`default_nettype wire

### src/esbr_stores.sv
`default_nettype none
module esbr_stores (
    input  wire logic                 i_clk,
    input  wire logic [15:0]          i_rd_addr,
    input  wire logic                 i_rd_en,
    input  wire esbr_pkg::t_store_wr  i_wr,
    output esbr_pkg::t_store_rd       o_rd
);

    logic [7:0] r_rom [esbr_pkg::ROM_PAGE_DEPTH];
    logic [7:0] r_str [esbr_pkg::STROBE_AREA_DEPTH];
    logic [7:0] r_reg [esbr_pkg::REGISTER_COUNT];

    logic [7:0] r_rom_q;
    logic [7:0] r_str_q;
    logic [7:0] r_reg_q;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rom_q <= r_rom[i_rd_addr[esbr_pkg::ROM_AW-1:0]];
            r_str_q <= r_str[i_rd_addr[esbr_pkg::STR_AW-1:0]];
            r_reg_q <= r_reg[i_rd_addr[esbr_pkg::REG_AW-1:0]];
        end
        if (i_wr.rom_we) begin
            r_rom[i_wr.addr[esbr_pkg::ROM_AW-1:0]] <= i_wr.data;
        end
        if (i_wr.str_we) begin
            r_str[i_wr.addr[esbr_pkg::STR_AW-1:0]] <= i_wr.data;
        end
        if (i_wr.reg_we) begin
            r_reg[i_wr.addr[esbr_pkg::REG_AW-1:0]] <= i_wr.data;
        end
    end

    assign o_rd.rom_q = r_rom_q;
    assign o_rd.str_q = r_str_q;
    assign o_rd.reg_q = r_reg_q;

endmodule
`default_nettype wire

### src/expansion_slot_bus_responder_core.sv
// Slot bus responder: each input word is one slot bus cycle or one preload byte.
// The stores (slot ROM page, 2 KiB strobe area, sixteen device registers, all
// synchronous RAMs) are read at the edge that accepts the word; then, in state
// S_EXEC, the core decides the drive, updates the strobe latch and writes back.
// So no new word is taken until the last one has been written back; the
// result sits in an output register, and the next word is accepted while it
// waits. While the result register is full and stalled, S_EXEC holds and
// input stall stays high. Store contents are undefined until written; the
// base registers sit at APB byte addresses 0 and 4 and reset to C100 and C090.
`default_nettype none
module expansion_slot_bus_responder_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_stall,
    input  wire esbr_pkg::t_in_word            i_in_word,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output      esbr_pkg::t_out_word           o_out_word,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [esbr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output      logic [31:0]                   prdata,
    output      logic                          pready
);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state              r_state;
    esbr_pkg::t_in_word  r_item;
    esbr_pkg::t_out_word r_out;
    esbr_pkg::t_out_word n_out;
    logic                r_out_valid;
    logic                r_latch;
    logic                n_latch;
    logic [15:0]         r_rom_page_base;
    logic [15:0]         r_register_base;

    esbr_pkg::t_store_wr s_wr;
    esbr_pkg::t_store_rd s_rd;

    logic s_accept;
    logic s_go;
    logic s_hit_page;
    logic s_in_strobe;
    logic s_hit_regs;
    logic s_drives;
    logic [7:0] s_drv;
    logic [7:0] s_data;

    assign o_in_stall = (r_state != S_IDLE);
    assign s_accept   = i_in_valid && (r_state == S_IDLE);
    assign s_go       = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    esbr_stores u_stores (
        .i_clk     (i_clk),
        .i_rd_addr (i_in_word.bus_address),
        .i_rd_en   (s_accept),
        .i_wr      (s_wr),
        .o_rd      (s_rd)
    );

    always_comb begin
        s_hit_page  = ((r_item.bus_address & esbr_pkg::PAGE_MASK) == r_rom_page_base);
        s_in_strobe = ((r_item.bus_address & esbr_pkg::STROBE_MASK) == esbr_pkg::STROBE_BASE);
        s_hit_regs  = ((r_item.bus_address & esbr_pkg::REG_MASK) == r_register_base);

        s_drives = 1'b0;
        s_drv    = 8'h00;
        n_latch  = r_latch;
        s_wr     = '0;
        s_wr.addr = r_item.bus_address;
        s_data   = r_item.bus_data;

        if (r_item.func == esbr_pkg::FUNC_PRELOAD) begin
            priority if (s_hit_page) begin
                s_wr.rom_we = s_go;
            end else if (s_in_strobe) begin
                s_wr.str_we = s_go;
            end else if (s_hit_regs) begin
                s_wr.reg_we = s_go;
            end else begin
                s_wr.reg_we = 1'b0;
            end
        end else begin
            // read selection uses the latch as it was before this cycle
            if (r_item.control_bits[0]) begin
                priority if (s_hit_page) begin
                    s_drives = 1'b1;
                    s_drv    = s_rd.rom_q;
                end else if (r_latch && s_in_strobe) begin
                    s_drives = 1'b1;
                    s_drv    = s_rd.str_q;
                end else if (s_hit_regs) begin
                    s_drives = 1'b1;
                    s_drv    = s_rd.reg_q;
                end else begin
                    s_drives = 1'b0;
                end
            end
            if (s_drives) begin
                s_data = s_drv;
            end
            priority if (r_item.bus_address == r_rom_page_base) begin
                n_latch = 1'b1;
            end else if (r_item.bus_address == esbr_pkg::STROBE_CLEAR_ADDR) begin
                n_latch = 1'b0;
            end else begin
                n_latch = r_latch;
            end
            // write-back uses the updated latch
            priority if (n_latch && s_in_strobe) begin
                s_wr.str_we = s_go;
            end else if (s_hit_regs) begin
                s_wr.reg_we = s_go;
            end else begin
                s_wr.reg_we = 1'b0;
            end
        end
        s_wr.data = s_data;

        n_out.card_drives    = s_drives;
        n_out.drive_byte     = s_drv;
        n_out.cycle_byte     = s_data;
        n_out.strobe_latched = n_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_latch     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (s_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (s_go) begin
                r_out_valid <= 1'b1;
                r_latch     <= n_latch;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s_accept) begin
            r_item <= i_in_word;
        end
        if (s_go) begin
            r_out <= n_out;
        end
    end

    // base registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_page_base <= esbr_pkg::ROM_PAGE_BASE_RESET;
            r_register_base <= esbr_pkg::REGISTER_BASE_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                esbr_pkg::REG_ROM_PAGE_BASE: r_rom_page_base <= pwdata[15:0];
                esbr_pkg::REG_REGISTER_BASE: r_register_base <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            esbr_pkg::REG_ROM_PAGE_BASE: prdata = {16'h0000, r_rom_page_base};
            esbr_pkg::REG_REGISTER_BASE: prdata = {16'h0000, r_register_base};
            default:                     prdata = 32'h0000_0000;
        endcase
    end

    assign pready      = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // an accepted word must lock out the next one until write-back is done
    a_accept_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("word accepted during read-modify-write");

    a_no_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.card_drives) |-> (o_out_word.drive_byte == 8'h00))
        else $error("drive byte nonzero while not driving");

    a_drive_traced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.card_drives) |->
            (o_out_word.cycle_byte == o_out_word.drive_byte))
        else $error("trace byte differs from driven byte");

    a_latch_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid || !i_rst_n)) |->
            (o_out_word.strobe_latched == r_latch))
        else $error("reported strobe latch differs from latch");

endmodule
`default_nettype wire
